>>> rtl/rmmm_pkg.sv
// ----------------------------------------------------------------------------
// rmmm_pkg: shared types for the running min/max/mean tracker
// Holds the sequencer state type of the top level.
// ----------------------------------------------------------------------------
package rmmm_pkg;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CALC,
        ST_PUSH
    } state_t;

endpackage

>>> rtl/rmmm_mean.sv
// ----------------------------------------------------------------------------
// rmmm_mean: bit-serial incremental mean step
// Computes mean + (x - mean) / divisor with the quotient truncated toward
// zero, one quotient bit per cycle through a restoring divider.
// ----------------------------------------------------------------------------
module rmmm_mean #(
    parameter int SAMPLE_BITS   = 13,
    parameter int FRACTION_BITS = 8,
    parameter int COUNT_BITS    = 20
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    input  logic [SAMPLE_BITS+FRACTION_BITS-1:0] mean,
    input  logic [SAMPLE_BITS-1:0]               sample,
    input  logic [COUNT_BITS:0]                  divisor,
    output logic                                 done,
    output logic [SAMPLE_BITS+FRACTION_BITS-1:0] result
);

    localparam int MW = SAMPLE_BITS + FRACTION_BITS;
    localparam int DW = COUNT_BITS + 1;
    localparam int CW = $clog2(MW + 1);

    logic          run_reg, run_next;
    logic          fin_reg, fin_next;
    logic          done_reg, done_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          neg_reg, neg_next;
    logic [MW-1:0] mean_reg, mean_next;
    logic [MW-1:0] quo_reg, quo_next;
    logic [DW-1:0] rem_reg, rem_next;
    logic [DW-1:0] div_reg, div_next;
    logic [MW-1:0] result_reg, result_next;

    logic [MW-1:0] x_full;
    logic [DW:0]   rem_shift;
    logic [DW:0]   rem_sub;

    always_comb
    begin
        x_full    = MW'(sample) << FRACTION_BITS;
        rem_shift = {rem_reg, quo_reg[MW-1]};
        rem_sub   = rem_shift - {1'b0, div_reg};

        run_next    = run_reg;
        fin_next    = 1'b0;
        done_next   = 1'b0;
        cnt_next    = cnt_reg;
        neg_next    = neg_reg;
        mean_next   = mean_reg;
        quo_next    = quo_reg;
        rem_next    = rem_reg;
        div_next    = div_reg;
        result_next = result_reg;

        if (start)
        begin
            // The magnitude of the difference is divided; the sign is kept aside.
            neg_next  = (x_full < mean);
            quo_next  = (x_full < mean) ? (mean - x_full) : (x_full - mean);
            mean_next = mean;
            div_next  = divisor;
            rem_next  = '0;
            cnt_next  = CW'(MW);
            run_next  = 1'b1;
        end
        else if (run_reg)
        begin
            // Restoring step: one quotient bit enters at the bottom each cycle.
            if (!rem_sub[DW])
            begin
                rem_next = rem_sub[DW-1:0];
                quo_next = {quo_reg[MW-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_shift[DW-1:0];
                quo_next = {quo_reg[MW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1))
            begin
                run_next = 1'b0;
                fin_next = 1'b1;
            end
        end
        else if (fin_reg)
        begin
            result_next = neg_reg ? (mean_reg - quo_reg) : (mean_reg + quo_reg);
            done_next   = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            fin_reg  <= fin_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg    <= neg_next;
        mean_reg   <= mean_next;
        quo_reg    <= quo_next;
        rem_reg    <= rem_next;
        div_reg    <= div_next;
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

>>> rtl/running_min_max_mean_tracker.sv
// ----------------------------------------------------------------------------
// running_min_max_mean_tracker: running statistics of paired sensor samples
// Tracks minimum, maximum and incremental mean of temperature and humidity.
// ----------------------------------------------------------------------------
// Each input beat carries one temperature and one humidity sample; each one
// produces exactly one output beat with the running minimum, maximum and
// mean of both channels and the saturating sample count. The means are
// unsigned fixed point with FRACTION_BITS fraction bits and are updated as
// mean + (x - mean) / (n + 1), the quotient truncated toward zero. The two
// channel divisions run side by side in bit-serial restoring dividers that
// produce one quotient bit per cycle. An item passes through loading, the
// quotient bits, the final add, collecting the result and handing it to
// the output register before the next item is accepted; the hand-off waits
// while the output register still holds a beat that was not taken. The
// output register holds a finished beat while the next item is already
// being worked on.
module running_min_max_mean_tracker #(
    parameter int SAMPLE_BITS   = 13,
    parameter int FRACTION_BITS = 8,
    parameter int COUNT_BITS    = 20
) (
    input  logic clk,
    input  logic rst_n,

    input  logic s_axis_tvalid,
    output logic s_axis_tready,
    // Fields from bit 0 up: temp_sample, humid_sample, zero fill.
    input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0] s_axis_tdata,

    output logic m_axis_tvalid,
    input  logic m_axis_tready,
    // Fields from bit 0 up: temp_min, temp_max, humid_min, humid_max,
    // temp_mean, humid_mean, samples_seen, zero fill.
    output logic [((4*SAMPLE_BITS+2*(SAMPLE_BITS+FRACTION_BITS)+COUNT_BITS+7)/8)*8-1:0]
                 m_axis_tdata
);

    import rmmm_pkg::*;

    localparam int S      = SAMPLE_BITS;
    localparam int MW     = SAMPLE_BITS + FRACTION_BITS;
    localparam int OUT_W  = 4*SAMPLE_BITS + 2*MW + COUNT_BITS;
    localparam int OUT_DW = ((OUT_W + 7) / 8) * 8;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    state_t state_reg, state_next;

    logic [COUNT_BITS-1:0] count_reg, count_next;
    logic [S-1:0]          temp_low_reg, temp_low_next;
    logic [S-1:0]          temp_high_reg, temp_high_next;
    logic [S-1:0]          humid_low_reg, humid_low_next;
    logic [S-1:0]          humid_high_reg, humid_high_next;
    logic [MW-1:0]         temp_avg_reg, temp_avg_next;
    logic [MW-1:0]         humid_avg_reg, humid_avg_next;
    logic                  out_valid_reg, out_valid_next;
    logic [OUT_W-1:0]      out_data_reg, out_data_next;

    logic [S-1:0]          temp_in;
    logic [S-1:0]          humid_in;
    logic                  accept;
    logic                  first;
    logic                  load_out;
    logic [COUNT_BITS:0]   divisor;
    logic                  temp_done;
    logic                  humid_done;
    logic [MW-1:0]         temp_result;
    logic [MW-1:0]         humid_result;

    assign temp_in  = s_axis_tdata[S-1:0];
    assign humid_in = s_axis_tdata[2*S-1:S];
    assign first    = (count_reg == '0);
    assign divisor  = {1'b0, count_reg} + (COUNT_BITS+1)'(1);

    // Both channels share the same divisor and start together, so they finish
    // in the same cycle.
    rmmm_mean #(
        .SAMPLE_BITS  (SAMPLE_BITS),
        .FRACTION_BITS(FRACTION_BITS),
        .COUNT_BITS   (COUNT_BITS)
    ) u_temp_mean (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (accept),
        .mean   (temp_avg_reg),
        .sample (temp_in),
        .divisor(divisor),
        .done   (temp_done),
        .result (temp_result)
    );

    rmmm_mean #(
        .SAMPLE_BITS  (SAMPLE_BITS),
        .FRACTION_BITS(FRACTION_BITS),
        .COUNT_BITS   (COUNT_BITS)
    ) u_humid_mean (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (accept),
        .mean   (humid_avg_reg),
        .sample (humid_in),
        .divisor(divisor),
        .done   (humid_done),
        .result (humid_result)
    );

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    state_next = ST_CALC;
                end
            end
            ST_CALC:
            begin
                if (temp_done)
                begin
                    state_next = ST_PUSH;
                end
            end
            ST_PUSH:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control outputs of the sequencer.
    always_comb
    begin
        s_axis_tready = (state_reg == ST_IDLE);
        accept        = s_axis_tready && s_axis_tvalid;
        load_out      = (state_reg == ST_PUSH) && (!out_valid_reg || m_axis_tready);
    end

    // Statistics update. Minimum and maximum settle at acceptance; the means
    // and the count follow once the dividers finish.
    always_comb
    begin
        temp_low_next   = temp_low_reg;
        temp_high_next  = temp_high_reg;
        humid_low_next  = humid_low_reg;
        humid_high_next = humid_high_reg;
        temp_avg_next   = temp_avg_reg;
        humid_avg_next  = humid_avg_reg;
        count_next      = count_reg;

        if (accept)
        begin
            if (first || temp_in < temp_low_reg)
            begin
                temp_low_next = temp_in;
            end
            if (first || temp_in > temp_high_reg)
            begin
                temp_high_next = temp_in;
            end
            if (first || humid_in < humid_low_reg)
            begin
                humid_low_next = humid_in;
            end
            if (first || humid_in > humid_high_reg)
            begin
                humid_high_next = humid_in;
            end
        end

        if ((state_reg == ST_CALC) && temp_done)
        begin
            temp_avg_next  = temp_result;
            humid_avg_next = humid_result;
            if (count_reg != COUNT_MAX)
            begin
                count_next = count_reg + COUNT_BITS'(1);
            end
        end
    end

    // Output register: a finished beat waits here while the next item runs.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
        if (load_out)
        begin
            out_valid_next = 1'b1;
            out_data_next  = {count_reg, humid_avg_reg, temp_avg_reg,
                              humid_high_reg, humid_low_reg,
                              temp_high_reg, temp_low_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            count_reg      <= '0;
            temp_low_reg   <= '0;
            temp_high_reg  <= '0;
            humid_low_reg  <= '0;
            humid_high_reg <= '0;
            temp_avg_reg   <= '0;
            humid_avg_reg  <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            temp_low_reg   <= temp_low_next;
            temp_high_reg  <= temp_high_next;
            humid_low_reg  <= humid_low_next;
            humid_high_reg <= humid_high_next;
            temp_avg_reg   <= temp_avg_next;
            humid_avg_reg  <= humid_avg_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    // The packed fields are zero-filled up to a whole number of bytes.
    always_comb
    begin
        m_axis_tdata = OUT_DW'(out_data_reg);
    end

    assign m_axis_tvalid = out_valid_reg;

    // The two channel dividers always run in lock step.
    a_done_together: assert property (@(posedge clk) disable iff (!rst_n)
        temp_done == humid_done)
        else $error("channel dividers finished in different cycles");

    // A divider result only appears while the sequencer waits for it.
    a_done_in_calc: assert property (@(posedge clk) disable iff (!rst_n)
        temp_done |-> state_reg == ST_CALC)
        else $error("divider finished outside the calculation phase");

    // Each mean stays between the channel minimum and maximum.
    a_temp_mean_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != '0 |->
            (temp_avg_reg >= (MW'(temp_low_reg) << FRACTION_BITS)) &&
            (temp_avg_reg <= (MW'(temp_high_reg) << FRACTION_BITS)))
        else $error("temperature mean left the min/max range");

    a_humid_mean_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != '0 |->
            (humid_avg_reg >= (MW'(humid_low_reg) << FRACTION_BITS)) &&
            (humid_avg_reg <= (MW'(humid_high_reg) << FRACTION_BITS)))
        else $error("humidity mean left the min/max range");

    // Once a sample has been absorbed the count never returns to zero.
    a_count_sticks: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != '0 |=> count_reg != '0)
        else $error("sample count fell back to zero");

endmodule
